@@ rtl/bsdh_pkg.sv @@
// Shared types and constants for the byte stream diff hunk finder.
// No dependencies; imported by byte_stream_diff_hunk_finder.
package bsdh_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int GAP_W           = 7;
    localparam int BYTE_W          = 8;
    localparam int OUT_W           = 32;

    localparam logic [GAP_W-1:0] MERGE_GAP_RESET = 7'd16;

    // Slave tdata: old_byte, new_byte. Master tdata: offset, length.
    localparam int IN_TDATA_W  = 2 * BYTE_W;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 2 * OUT_W;
    localparam int OUT_TUSER_W = 2;

    // Result queue depth; an input beat needs room for two records.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        OP_PAIR     = 2'd0,
        OP_OLD_ONLY = 2'd1,
        OP_NEW_ONLY = 2'd2,
        OP_END      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_HUNK    = 2'd0,
        KIND_EXPAND  = 2'd1,
        KIND_TRUNC   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [OUT_W-1:0] offset;
        logic [OUT_W-1:0] length;
        logic             last;
    } rec_t;

endpackage

@@ rtl/byte_stream_diff_hunk_finder.sv @@
// Byte stream diff hunk finder: compares old/new byte streams, emits hunk records.
// Depends on bsdh_pkg for types, codes and default constants.
//
// Usage:
//   Slave channel (s_*) takes one beat per item: s_tuser is the op (byte pair,
//   old-only tail byte, new-only tail byte, end of streams), s_tdata holds the
//   old and new bytes. Master channel (m_*) gives result records: m_tuser is the
//   kind, m_tdata the offset and length, m_tlast marks the final record of a beat.
//   The cfg channel writes merge_gap; write it only while no beat is in flight.
//   Flow: a beat is captured in the input register and, once the result queue
//   has room, processed into that four-entry queue, whose head drives m_*.
//   Throughput: one input beat per cycle while s_tready is high. An end mark
//   may give two records, which drain one per cycle while m_tready is high;
//   s_tready drops while the input register holds a beat and the queue has
//   less than two free entries.
//   Reset clears all stream state, empties the queue and sets merge_gap to 16.
//   When the receiver stalls, the queue fills and then the input register holds,
//   backing pressure onto s_tready; no record is lost or repeated.
module byte_stream_diff_hunk_finder #(
    parameter int OFFSET_BITS = bsdh_pkg::OFFSET_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bsdh_pkg::IN_TDATA_W-1:0] s_tdata,   // old_byte, new_byte
    input  logic [bsdh_pkg::IN_TUSER_W-1:0] s_tuser,   // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bsdh_pkg::OUT_TDATA_W-1:0] m_tdata,  // offset, length
    output logic [bsdh_pkg::OUT_TUSER_W-1:0] m_tuser,  // kind
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsdh_pkg::GAP_W-1:0]      cfg_data
);
    import bsdh_pkg::*;

    localparam int W  = OFFSET_BITS;
    localparam int MW = (W > OUT_W) ? W : OUT_W;
    localparam logic [W-1:0] OFF_MAX = {W{1'b1}};

    function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
        sat_inc = (v == OFF_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_W-1:0] clamp_out(input logic [W-1:0] v);
        logic [MW-1:0] wide;
        wide = MW'(v);
        clamp_out = (|(wide >> OUT_W)) ? {OUT_W{1'b1}} : wide[OUT_W-1:0];
    endfunction

    // Config register
    logic [GAP_W-1:0] merge_gap_reg;

    // Input register
    logic             in_valid_reg;
    op_t              op_reg;
    logic [BYTE_W-1:0] old_byte_reg;
    logic [BYTE_W-1:0] new_byte_reg;

    // Stream state
    logic [W-1:0]     pair_offset_reg, pair_offset_next;
    logic             hunk_open_reg, hunk_open_next;
    logic [W-1:0]     hunk_start_reg, hunk_start_next;
    logic [W-1:0]     last_diff_reg, last_diff_next;
    logic [GAP_W-1:0] equal_run_reg, equal_run_next;
    logic [W-1:0]     old_surplus_reg, old_surplus_next;
    logic [W-1:0]     new_surplus_reg, new_surplus_next;

    // Result queue
    rec_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    logic             advance;
    logic             pop;
    logic [1:0]       npush;
    rec_t             rec0, rec1;
    rec_t             hunk_rec, sur_rec;
    logic             has_sur;
    logic [GAP_W-1:0] gap_eff;
    logic [GAP_W-1:0] eq_inc;
    logic [W-1:0]     span;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (count_reg <= (QPTR_W+1)'(QDEPTH - 2));
    assign s_tready  = !in_valid_reg || advance;
    assign pop       = m_tvalid && m_tready;

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {q_reg[rd_ptr_reg].length, q_reg[rd_ptr_reg].offset};
    assign m_tuser  = q_reg[rd_ptr_reg].kind;
    assign m_tlast  = q_reg[rd_ptr_reg].last;

    always_comb
    begin
        gap_eff = (merge_gap_reg == '0) ? GAP_W'(1) : merge_gap_reg;
        eq_inc  = equal_run_reg + 1'b1;
        span    = last_diff_reg - hunk_start_reg;

        hunk_rec.kind   = KIND_HUNK;
        hunk_rec.offset = clamp_out(hunk_start_reg);
        hunk_rec.length = clamp_out((span == OFF_MAX) ? OFF_MAX : span + 1'b1);
        hunk_rec.last   = 1'b1;

        has_sur        = (new_surplus_reg != old_surplus_reg);
        sur_rec.offset = clamp_out(pair_offset_reg);
        sur_rec.last   = 1'b1;
        if (new_surplus_reg > old_surplus_reg)
        begin
            sur_rec.kind   = KIND_EXPAND;
            sur_rec.length = clamp_out(new_surplus_reg - old_surplus_reg);
        end
        else
        begin
            sur_rec.kind   = KIND_TRUNC;
            sur_rec.length = clamp_out(old_surplus_reg - new_surplus_reg);
        end

        rec0  = hunk_rec;
        rec1  = sur_rec;
        npush = 2'd0;

        pair_offset_next = pair_offset_reg;
        hunk_open_next   = hunk_open_reg;
        hunk_start_next  = hunk_start_reg;
        last_diff_next   = last_diff_reg;
        equal_run_next   = equal_run_reg;
        old_surplus_next = old_surplus_reg;
        new_surplus_next = new_surplus_reg;

        case (op_reg)
            OP_PAIR:
            begin
                if (old_byte_reg != new_byte_reg)
                begin
                    if (!hunk_open_reg)
                    begin
                        hunk_open_next  = 1'b1;
                        hunk_start_next = pair_offset_reg;
                    end
                    last_diff_next = pair_offset_reg;
                    equal_run_next = '0;
                end
                else if (hunk_open_reg)
                begin
                    if (eq_inc >= gap_eff)
                    begin
                        // gap reached: close the hunk
                        npush          = 2'd1;
                        hunk_open_next = 1'b0;
                        equal_run_next = '0;
                    end
                    else
                    begin
                        equal_run_next = eq_inc;
                    end
                end
                pair_offset_next = sat_inc(pair_offset_reg);
            end
            OP_OLD_ONLY:
            begin
                old_surplus_next = sat_inc(old_surplus_reg);
            end
            OP_NEW_ONLY:
            begin
                new_surplus_next = sat_inc(new_surplus_reg);
            end
            OP_END:
            begin
                if (hunk_open_reg)
                begin
                    rec0.last = !has_sur;
                    npush     = has_sur ? 2'd2 : 2'd1;
                end
                else if (has_sur)
                begin
                    rec0  = sur_rec;
                    npush = 2'd1;
                end
                pair_offset_next = '0;
                hunk_open_next   = 1'b0;
                hunk_start_next  = '0;
                last_diff_next   = '0;
                equal_run_next   = '0;
                old_surplus_next = '0;
                new_surplus_next = '0;
            end
            default:
            begin
                npush = 2'd0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_gap_reg   <= MERGE_GAP_RESET;
            in_valid_reg    <= 1'b0;
            pair_offset_reg <= '0;
            hunk_open_reg   <= 1'b0;
            hunk_start_reg  <= '0;
            last_diff_reg   <= '0;
            equal_run_reg   <= '0;
            old_surplus_reg <= '0;
            new_surplus_reg <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                merge_gap_reg <= cfg_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                pair_offset_reg <= pair_offset_next;
                hunk_open_reg   <= hunk_open_next;
                hunk_start_reg  <= hunk_start_next;
                last_diff_reg   <= last_diff_next;
                equal_run_reg   <= equal_run_next;
                old_surplus_reg <= old_surplus_next;
                new_surplus_reg <= new_surplus_next;
            end
            wr_ptr_reg <= wr_ptr_reg + (advance ? QPTR_W'(npush) : QPTR_W'(0));
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_reg + (advance ? (QPTR_W+1)'(npush) : (QPTR_W+1)'(0))
                          - (QPTR_W+1)'(pop);
        end
    end

    // Payload: input beat and queued records
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg       <= op_t'(s_tuser);
            old_byte_reg <= s_tdata[BYTE_W-1:0];
            new_byte_reg <= s_tdata[2*BYTE_W-1:BYTE_W];
        end
        if (advance && (npush != 2'd0))
        begin
            q_reg[wr_ptr_reg] <= rec0;
        end
        if (advance && (npush == 2'd2))
        begin
            q_reg[wr_ptr_reg + 1'b1] <= rec1;
        end
    end

endmodule

@@ tb/byte_stream_diff_hunk_finder_test.sv @@
// Self-checking testbench for byte_stream_diff_hunk_finder: drives byte pairs, tail bytes
// and end marks with random idling, and checks every hunk, expand and truncate record in order.
// Depends on bsdh_pkg and the byte_stream_diff_hunk_finder RTL.
`timescale 1ns / 1ps

module byte_stream_diff_hunk_finder_test;
    import bsdh_pkg::*;

    localparam int          RANDOM_ITEMS = 500;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          SETTLE       = 8;
    localparam logic [31:0] CNT_MAX      = 32'hFFFF_FFFF;

    // Tracks stream state and holds the records the block owes us.
    class hunk_scoreboard;
        rec_t             pending_recs[$];
        logic [GAP_W-1:0] merge_gap;
        logic [31:0]      pair_off;
        logic [31:0]      hunk_start;
        logic [31:0]      last_diff;
        logic [31:0]      old_tail;
        logic [31:0]      new_tail;
        logic             hunk_open;
        logic [GAP_W-1:0] equal_run;
        int               mismatches;

        function new();
            merge_gap  = MERGE_GAP_RESET;
            mismatches = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            pair_off   = '0;
            hunk_start = '0;
            last_diff  = '0;
            old_tail   = '0;
            new_tail   = '0;
            hunk_open  = 1'b0;
            equal_run  = '0;
        endfunction

        function logic [31:0] sat_inc(logic [31:0] v);
            return (v == CNT_MAX) ? CNT_MAX : v + 32'd1;
        endfunction

        function rec_t make_rec(kind_t k, logic [31:0] off, logic [31:0] len);
            rec_t r;
            r.kind   = k;
            r.offset = off;
            r.length = len;
            r.last   = 1'b0;
            return r;
        endfunction

        function rec_t close_hunk();
            logic [31:0] span;
            span      = last_diff - hunk_start;
            hunk_open = 1'b0;
            equal_run = '0;
            return make_rec(KIND_HUNK, hunk_start,
                            (span == CNT_MAX) ? CNT_MAX : span + 32'd1);
        endfunction

        function void set_gap(logic [GAP_W-1:0] v);
            merge_gap = v;
        endfunction

        function int pending();
            return pending_recs.size();
        endfunction

        function void note_input(op_t op, logic [7:0] ob, logic [7:0] nb);
            rec_t             recs[$];
            logic [GAP_W-1:0] gap_eff;
            gap_eff = (merge_gap == '0) ? GAP_W'(1) : merge_gap;
            case (op)
                OP_PAIR:
                begin
                    if (ob != nb)
                    begin
                        if (!hunk_open)
                        begin
                            hunk_open  = 1'b1;
                            hunk_start = pair_off;
                        end
                        last_diff = pair_off;
                        equal_run = '0;
                    end
                    else if (hunk_open)
                    begin
                        equal_run = equal_run + 1'b1;
                        if (equal_run >= gap_eff)
                            recs.push_back(close_hunk());
                    end
                    pair_off = sat_inc(pair_off);
                end
                OP_OLD_ONLY: old_tail = sat_inc(old_tail);
                OP_NEW_ONLY: new_tail = sat_inc(new_tail);
                default:
                begin
                    if (hunk_open)
                        recs.push_back(close_hunk());
                    // only the net surplus is reported
                    if (new_tail > old_tail)
                        recs.push_back(make_rec(KIND_EXPAND, pair_off, new_tail - old_tail));
                    else if (old_tail > new_tail)
                        recs.push_back(make_rec(KIND_TRUNC, pair_off, old_tail - new_tail));
                    clear_stream();
                end
            endcase
            if (recs.size() > 0)
                recs[recs.size() - 1].last = 1'b1;
            foreach (recs[i])
                pending_recs.push_back(recs[i]);
        endfunction

        function void report(string what, rec_t want, rec_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: %s: expected kind=%0d offset=%0d length=%0d last=%0d",
                         $realtime, what, want.kind, want.offset, want.length, want.last);
                $display("    got kind=%0d offset=%0d length=%0d last=%0d",
                         got.kind, got.offset, got.length, got.last);
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [31:0] off, logic [31:0] len,
                                   logic last);
            rec_t got;
            rec_t want;
            got.kind   = kind_t'(kind);
            got.offset = off;
            got.length = len;
            got.last   = last;
            if (pending_recs.size() == 0)
            begin
                want = '0;
                report("unexpected record", want, got);
                return;
            end
            want = pending_recs.pop_front();
            if (got.kind !== want.kind || got.offset !== want.offset ||
                got.length !== want.length || got.last !== want.last)
                report("record mismatch", want, got);
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;   // old_byte, new_byte
    logic [IN_TUSER_W-1:0]   s_tuser;   // op
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;   // offset, length
    logic [OUT_TUSER_W-1:0]  m_tuser;   // kind
    logic                    m_tlast;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [GAP_W-1:0]        cfg_data;

    hunk_scoreboard sb;
    int             items_sent  = 0;
    int             idle_cycles = 0;
    int             rx_wait     = 0;
    bit             tx_burst    = 1'b0;
    bit             rx_burst    = 1'b0;

    byte_stream_diff_hunk_finder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: check each record beat, then, outside bursts, may drop m_tready for a random stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tuser, m_tdata[31:0], m_tdata[63:32], m_tlast);
                if ($urandom_range(0, 49) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 10);
                if (rx_wait != 0)
                    m_tready <= 1'b0;
            end
            else if (!m_tready)
            begin
                if (rx_wait > 0)
                    rx_wait--;
                if (rx_wait == 0)
                    m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("byte_stream_diff_hunk_finder_test: FAIL");
        $finish;
    end

    // Idle for a drawn gap, then hold the beat until it is taken.
    task automatic send_item(op_t op, logic [7:0] ob, logic [7:0] nb);
        int gap;
        if ($urandom_range(0, 59) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {nb, ob};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(op, ob, nb);
        items_sent++;
    endtask

    // Drop valid and hold until every owed record is back and the pipe is empty.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_gap(logic [GAP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_gap(v);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_diff_pair();
        logic [7:0] ob;
        ob = 8'($urandom);
        send_item(OP_PAIR, ob, ob ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic send_equal_pair();
        logic [7:0] ob;
        ob = 8'($urandom);
        send_item(OP_PAIR, ob, ob);
    endtask

    // One stream pair: difference bursts separated by equal runs near the gap,
    // optional tails, sometimes pairs after the tails, then the end mark.
    task automatic send_stream(int n_segs, int gap_eff);
        int n_eq;
        int n_old;
        int n_new;
        for (int s = 0; s < n_segs; s++)
        begin
            repeat ($urandom_range(1, 4)) send_diff_pair();
            case ($urandom_range(0, 3))
                0:       n_eq = gap_eff;
                1:       n_eq = gap_eff - 1;
                2:       n_eq = $urandom_range(0, gap_eff + 2);
                default: n_eq = $urandom_range(0, 2);
            endcase
            repeat (n_eq) send_equal_pair();
        end
        n_old = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        n_new = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        repeat (n_old) send_item(OP_OLD_ONLY, 8'($urandom), 8'($urandom));
        repeat (n_new) send_item(OP_NEW_ONLY, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_item(OP_PAIR, 8'($urandom), 8'($urandom));
        send_item(OP_END, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(3, 12))
            send_item(op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        send_item(OP_END, 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        int gap_plan[7];
        int base;
        int phase;
        int gap_val;
        int gap_eff;
        int n_streams;

        gap_plan  = '{1, 127, 0, 64, 2, 5, 16};
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_PAIR;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset gap of 16, byte extremes, every op.
        send_item(OP_PAIR, 8'h00, 8'hFF);
        send_item(OP_PAIR, 8'hFF, 8'hFF);
        send_item(OP_PAIR, 8'h00, 8'h00);
        send_item(OP_PAIR, 8'hA5, 8'h5A);
        send_item(OP_END, 8'h00, 8'h00);
        // old tail longer, unused bytes set
        send_item(OP_OLD_ONLY, 8'hFF, 8'h00);
        send_item(OP_OLD_ONLY, 8'h00, 8'hFF);
        send_item(OP_NEW_ONLY, 8'h00, 8'hFF);
        send_item(OP_END, 8'hFF, 8'h00);
        send_item(OP_NEW_ONLY, 8'hFF, 8'hFF);
        send_item(OP_END, 8'hFF, 8'hFF);
        // empty stream, then tails that cancel
        send_item(OP_END, 8'h00, 8'h00);
        send_item(OP_OLD_ONLY, 8'h12, 8'h34);
        send_item(OP_NEW_ONLY, 8'h56, 8'h78);
        send_item(OP_END, 8'h00, 8'h00);
        // pairs after tail bytes; hunk and expand record from one end mark
        send_item(OP_PAIR, 8'h12, 8'h34);
        send_item(OP_NEW_ONLY, 8'h00, 8'h00);
        send_item(OP_NEW_ONLY, 8'hFF, 8'hFF);
        send_item(OP_PAIR, 8'h56, 8'h56);
        send_item(OP_PAIR, 8'h00, 8'h01);
        send_item(OP_END, 8'h00, 8'h00);
        // gap of zero behaves as one
        wait_drain();
        write_gap(GAP_W'(0));
        send_item(OP_PAIR, 8'h01, 8'h02);
        send_item(OP_PAIR, 8'h07, 8'h07);
        send_item(OP_END, 8'h00, 8'h00);

        base  = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            gap_val = (phase < 7) ? gap_plan[phase] : $urandom_range(1, 8);
            gap_eff = (gap_val == 0) ? 1 : gap_val;
            wait_drain();
            write_gap(GAP_W'(gap_val));
            n_streams = (gap_eff > 20) ? 2 : 6;
            for (int st = 0; st < n_streams; st++)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_noise();
                else
                    send_stream((gap_eff > 20) ? 1 : $urandom_range(1, 4), gap_eff);
                // hold the sender mid-phase until the block has fully drained
                if (st == 2 && phase[0])
                    wait_drain();
            end
            phase++;
        end

        wait_drain();
        repeat (SETTLE) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("byte_stream_diff_hunk_finder_test: PASS");
        else
            $display("byte_stream_diff_hunk_finder_test: FAIL");
        $finish;
    end

endmodule
